// ----- hw/rtl/ets_pkg.sv -----
// Shared types, constants and keyword lookup for the expression token scanner
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

    localparam int MantissaBits = 48;
    localparam int PositionBits = 16;
    localparam int WordChars    = 4;
    localparam int WordIdxBits  = $clog2(WordChars);
    localparam int WordLenBits  = $clog2(WordChars + 1);
    localparam int FracBits     = 6;
    localparam int KindBits     = 5;
    localparam int MaxResults   = 3;
    localparam int CountBits    = 2;

    localparam logic [KindBits-1:0] KindPlus    = 5'd0;
    localparam logic [KindBits-1:0] KindMinus   = 5'd1;
    localparam logic [KindBits-1:0] KindTimes   = 5'd2;
    localparam logic [KindBits-1:0] KindDivide  = 5'd3;
    localparam logic [KindBits-1:0] KindLParen  = 5'd4;
    localparam logic [KindBits-1:0] KindRParen  = 5'd5;
    localparam logic [KindBits-1:0] KindPower   = 5'd6;
    localparam logic [KindBits-1:0] KindNumber  = 5'd7;
    localparam logic [KindBits-1:0] KindSin     = 5'd8;
    localparam logic [KindBits-1:0] KindCos     = 5'd9;
    localparam logic [KindBits-1:0] KindTan     = 5'd10;
    localparam logic [KindBits-1:0] KindSqrt    = 5'd11;
    localparam logic [KindBits-1:0] KindLn      = 5'd12;
    localparam logic [KindBits-1:0] KindPi      = 5'd13;
    localparam logic [KindBits-1:0] KindE       = 5'd14;
    localparam logic [KindBits-1:0] KindEnd     = 5'd15;
    localparam logic [KindBits-1:0] KindBadChar = 5'd16;
    localparam logic [KindBits-1:0] KindBadWord = 5'd17;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_INT  = 5'b00010,
        MODE_DOT  = 5'b00100,
        MODE_FRAC = 5'b01000,
        MODE_WORD = 5'b10000
    } scan_mode_t;

    typedef logic [WordChars-1:0][7:0] word_buf_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic [KindBits-1:0]     result_kind;
        logic [PositionBits-1:0] token_pos;
        logic [MantissaBits-1:0] mantissa;
        logic [FracBits-1:0]     frac_digits;
        logic                    mantissa_overflow;
        logic                    last;
    } out_item_t;

    // all results caused by one item, in order
    typedef struct packed {
        logic [CountBits-1:0]            count;
        out_item_t [MaxResults-1:0]      res;
    } bundle_t;

    function automatic out_item_t make_result(
        input logic [KindBits-1:0]     kind,
        input logic [PositionBits-1:0] pos,
        input logic [MantissaBits-1:0] mant,
        input logic [FracBits-1:0]     frac,
        input logic                    ovf
    );
        out_item_t r;
        r.result_kind       = kind;
        r.token_pos         = pos;
        r.mantissa          = mant;
        r.frac_digits       = frac;
        r.mantissa_overflow = ovf;
        r.last              = 1'b0;
        return r;
    endfunction

    function automatic logic [KindBits-1:0] word_kind(
        input word_buf_t              wbuf,
        input logic [WordLenBits-1:0] wlen
    );
        logic [KindBits-1:0] k;
        k = KindBadWord;
        if (wlen == WordLenBits'(3) && wbuf[0] == "s" && wbuf[1] == "i" && wbuf[2] == "n")
            k = KindSin;
        else if (wlen == WordLenBits'(3) && wbuf[0] == "c" && wbuf[1] == "o"
                 && wbuf[2] == "s")
            k = KindCos;
        else if (wlen == WordLenBits'(3) && wbuf[0] == "t" && wbuf[1] == "a"
                 && wbuf[2] == "n")
            k = KindTan;
        else if (wlen == WordLenBits'(4) && wbuf[0] == "s" && wbuf[1] == "q"
                 && wbuf[2] == "r" && wbuf[3] == "t")
            k = KindSqrt;
        else if (wlen == WordLenBits'(2) && wbuf[0] == "l" && wbuf[1] == "n")
            k = KindLn;
        else if (wlen == WordLenBits'(2) && wbuf[0] == "P" && wbuf[1] == "I")
            k = KindPi;
        else if (wlen == WordLenBits'(1) && wbuf[0] == "E")
            k = KindE;
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ets_core.sv -----
// Scanner state and per-item token logic: one item in, a bundle of up to three results out
`timescale 1ns / 1ps
`default_nettype none

module ets_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire ets_pkg::in_item_t item,
    output ets_pkg::bundle_t       bundle
);

    localparam int M = ets_pkg::MantissaBits;

    ets_pkg::scan_mode_t                    mode_reg, mode_next;
    logic [ets_pkg::PositionBits-1:0]       pos_reg, pos_next;
    logic [M-1:0]                           acc_reg, acc_next;
    logic [ets_pkg::FracBits-1:0]           frac_reg, frac_next;
    logic                                   sat_reg, sat_next;
    ets_pkg::word_buf_t                     wbuf_reg, wbuf_next;
    logic [ets_pkg::WordLenBits-1:0]        wlen_reg, wlen_next;
    logic                                   wlong_reg, wlong_next;

    logic [7:0]     c;
    logic           is_digit, is_letter, is_dot, is_space, is_op;
    logic [3:0]     dval;
    logic [M+3:0]   acc_wide;
    logic           add_ovf;
    logic [M-1:0]   acc_add;
    logic [ets_pkg::KindBits-1:0] op_kind;
    logic           cont;

    assign c         = item.char_code;
    assign is_digit  = (c >= "0") && (c <= "9");
    assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_dot    = (c == ".");
    assign is_space  = (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D);
    assign dval      = 4'(c - "0");

    // acc*10 + d, saturating when the result leaves the mantissa range
    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + (M+4)'(dval);
    assign add_ovf  = sat_reg || (|acc_wide[M+3:M]);
    assign acc_add  = add_ovf ? {M{1'b1}} : acc_wide[M-1:0];

    always_comb
    begin
        is_op   = 1'b1;
        op_kind = ets_pkg::KindPlus;
        unique case (c)
            "+":     op_kind = ets_pkg::KindPlus;
            "-":     op_kind = ets_pkg::KindMinus;
            "*":     op_kind = ets_pkg::KindTimes;
            "/":     op_kind = ets_pkg::KindDivide;
            "(":     op_kind = ets_pkg::KindLParen;
            ")":     op_kind = ets_pkg::KindRParen;
            "^":     op_kind = ets_pkg::KindPower;
            default: is_op = 1'b0;
        endcase
    end

    // item extends the pending number or word without ending it
    assign cont = !item.is_end
        && (((mode_reg == ets_pkg::MODE_INT) && (is_digit || is_dot))
            || (((mode_reg == ets_pkg::MODE_DOT) || (mode_reg == ets_pkg::MODE_FRAC))
                && is_digit)
            || ((mode_reg == ets_pkg::MODE_WORD) && is_letter));

    always_comb
    begin
        logic [ets_pkg::CountBits-1:0]    n;
        logic [ets_pkg::PositionBits-1:0] p;
        ets_pkg::out_item_t [ets_pkg::MaxResults-1:0] res;

        n   = '0;
        p   = pos_reg;
        res = '0;

        if (!cont)
        begin
            // flush the pending token
            if ((mode_reg == ets_pkg::MODE_INT) || (mode_reg == ets_pkg::MODE_DOT)
                || (mode_reg == ets_pkg::MODE_FRAC))
            begin
                res[n] = ets_pkg::make_result(ets_pkg::KindNumber, p, acc_reg, frac_reg,
                                              sat_reg);
                n = n + 2'd1;
                p = p + 1'b1;
            end
            // a trailing dot with no digit after it
            if (mode_reg == ets_pkg::MODE_DOT)
            begin
                res[n] = ets_pkg::make_result(ets_pkg::KindBadChar, p, '0, '0, 1'b0);
                n = n + 2'd1;
                p = p + 1'b1;
            end
            if (mode_reg == ets_pkg::MODE_WORD)
            begin
                res[n] = ets_pkg::make_result(
                    wlong_reg ? ets_pkg::KindBadWord
                              : ets_pkg::word_kind(wbuf_reg, wlen_reg),
                    p, '0, '0, 1'b0);
                n = n + 2'd1;
                p = p + 1'b1;
            end

            if (item.is_end)
            begin
                res[n] = ets_pkg::make_result(ets_pkg::KindEnd, p, '0, '0, 1'b0);
                n = n + 2'd1;
                p = p + 1'b1;
            end
            else if (is_op)
            begin
                res[n] = ets_pkg::make_result(op_kind, p, '0, '0, 1'b0);
                n = n + 2'd1;
                p = p + 1'b1;
            end
            else if (is_space)
            begin
                p = p + 1'b1;
            end
            else if (!is_digit && !is_letter)
            begin
                res[n] = ets_pkg::make_result(ets_pkg::KindBadChar, p, '0, '0, 1'b0);
                n = n + 2'd1;
                p = p + 1'b1;
            end
        end

        bundle.count = n;
        bundle.res   = res;
        pos_next     = item.is_end ? '0 : p;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        sat_next   = sat_reg;
        wbuf_next  = wbuf_reg;
        wlen_next  = wlen_reg;
        wlong_next = wlong_reg;

        if (item.is_end)
        begin
            mode_next  = ets_pkg::MODE_IDLE;
            acc_next   = '0;
            frac_next  = '0;
            sat_next   = 1'b0;
            wlen_next  = '0;
            wlong_next = 1'b0;
        end
        else if (cont)
        begin
            if (mode_reg == ets_pkg::MODE_WORD)
            begin
                if (wlen_reg < ets_pkg::WordLenBits'(ets_pkg::WordChars))
                begin
                    wbuf_next[wlen_reg[ets_pkg::WordIdxBits-1:0]] = c;
                    wlen_next = wlen_reg + 1'b1;
                end
                else
                begin
                    wlong_next = 1'b1;
                end
            end
            else if (is_dot)
            begin
                mode_next = ets_pkg::MODE_DOT;
            end
            else
            begin
                acc_next = acc_add;
                sat_next = add_ovf;
                if (mode_reg == ets_pkg::MODE_DOT)
                begin
                    mode_next = ets_pkg::MODE_FRAC;
                    frac_next = ets_pkg::FracBits'(1);
                end
                else if ((mode_reg == ets_pkg::MODE_FRAC) && (frac_reg != '1))
                begin
                    frac_next = frac_reg + 1'b1;
                end
            end
        end
        else if (is_digit)
        begin
            mode_next = ets_pkg::MODE_INT;
            acc_next  = M'(dval);
            frac_next = '0;
            sat_next  = 1'b0;
        end
        else if (is_letter)
        begin
            mode_next  = ets_pkg::MODE_WORD;
            wbuf_next[0] = c;
            wlen_next  = ets_pkg::WordLenBits'(1);
            wlong_next = 1'b0;
        end
        else
        begin
            mode_next = ets_pkg::MODE_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ets_pkg::MODE_IDLE;
            pos_reg   <= '0;
            acc_reg   <= '0;
            frac_reg  <= '0;
            sat_reg   <= 1'b0;
            wlen_reg  <= '0;
            wlong_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            sat_reg   <= sat_next;
            wlen_reg  <= wlen_next;
            wlong_reg <= wlong_next;
        end
    end

    // word letters: only entries already written are read
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            wbuf_reg <= wbuf_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/expression_token_scanner_unit.sv -----
// Top level: input register, scanner core, two-bundle result queue and output serialiser
`timescale 1ns / 1ps
`default_nettype none

// Path: a result is offered once its item has passed the input register and then
// the bundle queue register.
// Throughput: one item per cycle while the queue has room; an item with k results holds
// the output until all k are taken, and the two-bundle queue absorbs that before the input stalls.
// Reset: queue and input register empty, scanner idle, position counter zero.
module expression_token_scanner_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire ets_pkg::in_item_t  src_item,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output ets_pkg::out_item_t      tok_item
);

    logic                           in_vld_reg, in_vld_next;
    ets_pkg::in_item_t              in_item_reg;
    logic [1:0]                     q_cnt_reg, q_cnt_next;
    ets_pkg::bundle_t               q0_reg, q0_next, q1_reg, q1_next;
    logic [ets_pkg::CountBits-1:0]  idx_reg, idx_next;

    logic             accept, step, push, pop, bundle_done, full;
    ets_pkg::bundle_t bundle;

    assign full      = (q_cnt_reg == 2'd2);
    assign src_stall = in_vld_reg && full;
    assign accept    = src_valid && !src_stall;
    assign step      = in_vld_reg && !full;
    assign push      = step && (bundle.count != '0);

    ets_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    assign tok_valid   = (q_cnt_reg != 2'd0);
    assign pop         = tok_valid && !tok_stall;
    assign bundle_done = pop && (idx_reg == q0_reg.count - 1'b1);

    always_comb
    begin
        tok_item      = q0_reg.res[idx_reg];
        tok_item.last = (idx_reg == q0_reg.count - 1'b1);
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;

        idx_next = idx_reg;
        if (bundle_done)
            idx_next = '0;
        else if (pop)
            idx_next = idx_reg + 1'b1;

        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q_cnt_next = q_cnt_reg;
        if (bundle_done)
        begin
            q0_next    = q1_reg;
            q_cnt_next = q_cnt_reg - 1'b1;
        end
        if (push)
        begin
            // slot left free after this cycle's shift
            if (q_cnt_next == 2'd0)
                q0_next = bundle;
            else
                q1_next = bundle;
            q_cnt_next = q_cnt_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            q_cnt_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            q_cnt_reg  <= q_cnt_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= src_item;
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

// ----- sim/expression_token_scanner_unit_tb.sv -----
// Self-checking testbench for the expression token scanner unit
`timescale 1ns / 1ps

module expression_token_scanner_unit_tb;

    import ets_pkg::*;

    localparam int QuietLimit = 1000;
    localparam int DrainCycles = 20;

    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChReturn  = 8'h0D;
    localparam logic [7:0] ChDot     = 8'h2E;

    localparam logic [MantissaBits-1:0] MantMax = '1;
    localparam logic [FracBits-1:0]     FracMax = '1;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    in_item_t  src_item;
    logic      tok_valid;
    logic      tok_stall;
    out_item_t tok_item;

    expression_token_scanner_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    // scanner state as predicted
    scan_mode_t              scan_state;
    logic [PositionBits-1:0] pos_count;
    logic [MantissaBits-1:0] digit_acc;
    logic [FracBits-1:0]     frac_count;
    logic                    acc_sat;
    word_buf_t               word_chars;
    int unsigned             word_len;
    logic                    word_overlong;

    out_item_t pending_tokens[$];
    out_item_t step_tokens[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;
    int hold_off_len   = 0;

    string      operator_chars = "+-*/()^";
    string      keyword_text[7] = '{"sin", "cos", "tan", "sqrt", "ln", "PI", "E"};
    logic [7:0] blank_chars[4] = '{ChSpace, ChTab, ChNewline, ChReturn};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void clear_scanner();
        scan_state    = MODE_IDLE;
        pos_count     = '0;
        digit_acc     = '0;
        frac_count    = '0;
        acc_sat       = 1'b0;
        word_chars    = '0;
        word_len      = 0;
        word_overlong = 1'b0;
    endfunction

    function automatic void push_token(logic [KindBits-1:0] kind,
                                       logic [MantissaBits-1:0] mant,
                                       logic [FracBits-1:0] frac, logic ovf);
        out_item_t t;
        t.result_kind       = kind;
        t.token_pos         = pos_count;
        t.mantissa          = mant;
        t.frac_digits       = frac;
        t.mantissa_overflow = ovf;
        t.last              = 1'b0;
        step_tokens.push_back(t);
        pos_count++;
    endfunction

    function automatic void accumulate_digit(logic [7:0] c);
        logic [MantissaBits-1:0] d;
        d = MantissaBits'(c - "0");
        if (acc_sat || digit_acc > (MantMax - d) / 10)
        begin
            digit_acc = MantMax;
            acc_sat   = 1'b1;
        end
        else
        begin
            digit_acc = digit_acc * 10 + d;
        end
    endfunction

    function automatic logic [KindBits-1:0] keyword_kind();
        logic [8*WordChars-1:0] w;
        logic [KindBits-1:0]    k;
        w = '0;
        k = KindBadWord;
        for (int i = 0; i < word_len; i++)
            w = {w[8*WordChars-9:0], word_chars[i]};
        if (!word_overlong)
        begin
            case (word_len)
                1: if (w == "E") k = KindE;
                2:
                begin
                    if (w == "ln") k = KindLn;
                    else if (w == "PI") k = KindPi;
                end
                3:
                begin
                    if (w == "sin") k = KindSin;
                    else if (w == "cos") k = KindCos;
                    else if (w == "tan") k = KindTan;
                end
                4: if (w == "sqrt") k = KindSqrt;
                default: ;
            endcase
        end
        return k;
    endfunction

    function automatic void flush_token();
        case (scan_state)
            MODE_INT, MODE_DOT, MODE_FRAC:
            begin
                push_token(KindNumber, digit_acc, frac_count, acc_sat);
                // dangling dot is reported after the number
                if (scan_state == MODE_DOT)
                    push_token(KindBadChar, '0, '0, 1'b0);
            end
            MODE_WORD: push_token(keyword_kind(), '0, '0, 1'b0);
            default: ;
        endcase
        scan_state = MODE_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c);
        case (c)
            "+": push_token(KindPlus, '0, '0, 1'b0);
            "-": push_token(KindMinus, '0, '0, 1'b0);
            "*": push_token(KindTimes, '0, '0, 1'b0);
            "/": push_token(KindDivide, '0, '0, 1'b0);
            "(": push_token(KindLParen, '0, '0, 1'b0);
            ")": push_token(KindRParen, '0, '0, 1'b0);
            "^": push_token(KindPower, '0, '0, 1'b0);
            ChSpace, ChTab, ChNewline, ChReturn: pos_count++;
            default:
            begin
                if (is_digit(c))
                begin
                    digit_acc  = '0;
                    frac_count = '0;
                    acc_sat    = 1'b0;
                    accumulate_digit(c);
                    scan_state = MODE_INT;
                end
                else if (is_letter(c))
                begin
                    word_chars[0] = c;
                    word_len      = 1;
                    word_overlong = 1'b0;
                    scan_state    = MODE_WORD;
                end
                else
                begin
                    push_token(KindBadChar, '0, '0, 1'b0);
                end
            end
        endcase
    endfunction

    // works out the tokens that one accepted item causes
    function automatic void scan_item(in_item_t it);
        logic [7:0] c;
        logic       absorbed;
        c        = it.char_code;
        absorbed = 1'b0;
        step_tokens.delete();
        if (it.is_end)
        begin
            flush_token();
            push_token(KindEnd, '0, '0, 1'b0);
            clear_scanner();
        end
        else
        begin
            case (scan_state)
                MODE_INT:
                begin
                    if (is_digit(c))
                    begin
                        accumulate_digit(c);
                        absorbed = 1'b1;
                    end
                    else if (c == ChDot)
                    begin
                        scan_state = MODE_DOT;
                        absorbed   = 1'b1;
                    end
                end
                MODE_DOT:
                begin
                    if (is_digit(c))
                    begin
                        accumulate_digit(c);
                        frac_count = FracBits'(1);
                        scan_state = MODE_FRAC;
                        absorbed   = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        accumulate_digit(c);
                        if (frac_count != FracMax)
                            frac_count++;
                        absorbed = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (is_letter(c))
                    begin
                        if (word_len < WordChars)
                        begin
                            word_chars[word_len] = c;
                            word_len++;
                        end
                        else
                        begin
                            word_overlong = 1'b1;
                        end
                        absorbed = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!absorbed)
            begin
                flush_token();
                start_token(c);
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : token_check
        out_item_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: token with none expected, expected nothing, actual %h",
                         $time, tok_item);
            end
            else
            begin
                want = pending_tokens.pop_front();
                compare_field("result_kind", want.result_kind, tok_item.result_kind);
                compare_field("token_pos", want.token_pos, tok_item.token_pos);
                compare_field("mantissa", want.mantissa, tok_item.mantissa);
                compare_field("frac_digits", want.frac_digits, tok_item.frac_digits);
                compare_field("mantissa_overflow", want.mantissa_overflow,
                              tok_item.mantissa_overflow);
                compare_field("last", want.last, tok_item.last);
            end
        end
    end

    // token receiver: random stalls, or a long hold-off when asked
    initial
    begin : token_sink
        tok_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                tok_stall <= 1'b1;
                hold_off_len--;
            end
            else
            begin
                tok_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QuietLimit)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("expression_token_scanner_unit verification failed");
        $finish;
    end

    // valid stays high after acceptance; the next call or a pause decides
    task automatic send_char(logic [7:0] c, logic end_mark);
        in_item_t it;
        it.char_code = c;
        it.is_end    = end_mark;
        while ($urandom_range(99) < gap_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do
            @(posedge clk);
        while (src_stall);
        scan_item(it);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    task automatic send_digits(int count);
        for (int i = 0; i < count; i++)
            send_char(8'("0" + $urandom_range(9)), 1'b0);
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // number, fraction, second dot, then a dot with no digit after it
    task automatic test_number_dots();
        send_text("1.5.27.+");
    endtask

    task automatic test_long_word();
        send_text("sqrtxE ");
    endtask

    task automatic test_operators();
        send_text(operator_chars);
    endtask

    task automatic test_blanks_and_byte_extremes();
        send_char(ChTab, 1'b0);
        send_char(ChReturn, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps going, so the input stalls
    task automatic test_output_backpressure();
        gap_pct      = 0;
        stall_pct    = 0;
        hold_off_len = 60;
        repeat (24)
            send_char(operator_chars[$urandom_range(6)], 1'b0);
        wait_drained();
    endtask

    // mantissa and fraction count both run into saturation
    task automatic test_saturating_number();
        gap_pct   = 29;
        stall_pct = 29;
        send_char(8'("1" + $urandom_range(8)), 1'b0);
        send_digits(17);
        send_char(ChDot, 1'b0);
        send_digits(64);
        send_char(8'($urandom_range(255)), 1'b1);
        wait_drained();
    endtask

    task automatic send_random_fragment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            send_char(operator_chars[$urandom_range(6)], 1'b0);
        end
        else if (pick < 45)
        begin
            send_digits(($urandom_range(9) == 0) ? $urandom_range(16, 18)
                                                 : $urandom_range(1, 3));
            if ($urandom_range(1))
            begin
                send_char(ChDot, 1'b0);
                send_digits($urandom_range(0, 3));
                if ($urandom_range(4) == 0)
                    send_char(ChDot, 1'b0);
            end
        end
        else if (pick < 62)
        begin
            send_text(keyword_text[$urandom_range(6)]);
        end
        else if (pick < 72)
        begin
            send_char(blank_chars[$urandom_range(3)], 1'b0);
        end
        else if (pick < 84)
        begin
            send_char(8'($urandom_range(255)), 1'b0);
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 7))
                send_char(8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)), 1'b0);
        end
        else
        begin
            send_char(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic test_random_text(int gap, int stall, int item_count);
        int target;
        gap_pct   = gap;
        stall_pct = stall;
        target    = items_sent + item_count;
        while (items_sent < target)
            send_random_fragment();
        wait_drained();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_item  <= '0;
        clear_scanner();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_number_dots();
        test_long_word();
        test_operators();
        test_blanks_and_byte_extremes();
        test_output_backpressure();
        test_saturating_number();
        test_random_text(0, 0, 20);
        test_random_text(87, 0, 20);
        test_random_text(0, 87, 20);
        test_random_text(29, 29, 20);

        src_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0 && pending_tokens.size() == 0)
            $display("expression_token_scanner_unit verification clean");
        else
            $display("expression_token_scanner_unit verification failed");
        $finish;
    end

endmodule
